/* hw/rtl/bec_pkg.sv */
`default_nettype none

package bec_pkg;

   // Widest row the block handles; one bit per pixel column.
   localparam int MAX_WIDTH = 64;
   localparam int ROW_W = MAX_WIDTH;

   // Width register and the fixed APB-style port.
   localparam int CFG_W = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_IMAGE_WIDTH = 1'b0;

   // Result queue: two free entries are needed before a row is processed.
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   // One result word as it sits in the queue.
   typedef struct packed {
      logic [ROW_W-1:0] eroded_row;
      logic             last_result;
      logic             possible;
   } rsp_word_type;

   // Horizontal three-wide AND; columns outside the row count as black.
   function automatic logic [ROW_W-1:0] hand3(input logic [ROW_W-1:0] x,
                                              input logic [ROW_W-1:0] m,
                                              input logic [ROW_W-1:0] top);
      logic [ROW_W-1:0] xm;
      xm = x & m;
      return xm & ((xm << 1) | ROW_W'(1)) & ((xm >> 1) | top) & m;
   endfunction

   // Horizontal three-wide OR; columns outside the row count as white.
   function automatic logic [ROW_W-1:0] hor3(input logic [ROW_W-1:0] x,
                                             input logic [ROW_W-1:0] m);
      logic [ROW_W-1:0] xm;
      xm = x & m;
      return (xm | (xm << 1) | (xm >> 1)) & m;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/bec_ifs.sv */
`default_nettype none

// Row channel into the block.
interface bec_req_if;
   logic                       valid;
   logic                       ready;
   logic [bec_pkg::ROW_W-1:0]  row_bits;
   logic                       last_row;

   modport source (output valid, output row_bits, output last_row, input ready);
   modport sink (input valid, input row_bits, input last_row, output ready);
endinterface

// Eroded row channel out of the block.
interface bec_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bec_pkg::ROW_W-1:0]  eroded_row;
   logic                       last_result;
   logic                       possible;

   modport source (output valid, output eroded_row, output last_result, output possible,
                   input ready);
   modport sink (input valid, input eroded_row, input last_result, input possible,
                 output ready);
endinterface

`default_nettype wire

/* hw/rtl/binary_erode_and_opening_check.sv */
// 3x3 binary erosion of a streamed image with an opening check.
// req_ch takes one image row per word (bit k is column k, 1 is black) and a
// last_row flag on the bottom row. rsp_ch returns each row eroded, one row
// late; the bottom row returns two words (one in a one-row image), the last
// with last_result set and possible telling whether dilating the eroded
// image gives the original back. The csr_ port holds image_width (columns
// per row, 0 acts as 1, above 64 as 64); write it only while no image is
// in flight. The eroded word for row r is queued when row r+1 leaves the
// input register, and the bottom row's own word is queued right behind it.
// Throughput: one row per cycle. A row goes into an input register, and one
// pass of logic erodes it into a four-word result queue; a row moves on only
// when the queue has two free words, as the bottom row pushes two words.
// When rsp_ch stalls the queue fills and req_ch ready drops; no word is lost.
// Reset empties the input register and the queue, clears the stored rows and
// sets image_width to 64.
`default_nettype none

module binary_erode_and_opening_check (
   input  wire                               clock,
   input  wire                               reset,
   bec_req_if.sink                           req_ch,
   bec_rsp_if.source                         rsp_ch,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire [bec_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire [bec_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bec_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int W = bec_pkg::ROW_W;

   // Configuration.
   logic [bec_pkg::CFG_W-1:0] width_ff, width_in;

   // Input register.
   logic         in_vld_ff, in_vld_in;
   logic [W-1:0] in_row_ff, in_row_in;
   logic         in_last_ff, in_last_in;

   // Image state.
   logic [W-1:0] orig_prev_ff, orig_prev_in;
   logic [W-1:0] orig_prev2_ff, orig_prev2_in;
   logic [W-1:0] ero_prev_ff, ero_prev_in;
   logic [W-1:0] ero_prev2_ff, ero_prev2_in;
   logic [1:0]   rows_seen_ff, rows_seen_in;
   logic         still_ok_ff, still_ok_in;

   // Result queue.
   bec_pkg::rsp_word_type           rq_mem_ff [bec_pkg::RQ_DEPTH];
   logic [bec_pkg::RQ_PTR_W-1:0]    rq_head_ff, rq_head_in;
   logic [bec_pkg::RQ_PTR_W-1:0]    rq_tail_ff, rq_tail_in;
   logic [bec_pkg::RQ_CNT_W-1:0]    rq_cnt_ff, rq_cnt_in;

   // Datapath nets.
   logic                 csr_wr;
   logic                 req_acc, consume, pop;
   logic [bec_pkg::CFG_W-1:0] eff_w;
   logic [W-1:0]         m, top, cur, above_cur, above;
   logic                 has1, has2;
   logic [W-1:0]         e1, el, dil1, dil2, dil3;
   logic                 ok1, ok2, ok3, verdict;
   logic [1:0]           push_n;
   bec_pkg::rsp_word_type word_a, word_b;

   // Configuration port: one register, always ready.
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == bec_pkg::CSR_IDX_IMAGE_WIDTH);
   assign csr_prdata = (csr_paddr[2] == bec_pkg::CSR_IDX_IMAGE_WIDTH)
                       ? bec_pkg::CSR_DATA_W'(width_ff) : '0;
   assign width_in = csr_wr ? csr_pwdata[bec_pkg::CFG_W-1:0] : width_ff;

   // Handshakes: the input register drains when the queue has two free words.
   assign consume = in_vld_ff
                    && (rq_cnt_ff <= bec_pkg::RQ_CNT_W'(bec_pkg::RQ_DEPTH - 2));
   assign req_ch.ready = !in_vld_ff || consume;
   assign req_acc = req_ch.valid && req_ch.ready;
   assign pop = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      in_vld_in  = req_acc ? 1'b1 : (consume ? 1'b0 : in_vld_ff);
      in_row_in  = req_acc ? req_ch.row_bits : in_row_ff;
      in_last_in = req_acc ? req_ch.last_row : in_last_ff;
   end

   // Effective width, column mask and the top-column bit.
   always_comb begin
      if (width_ff == '0) begin
         eff_w = bec_pkg::CFG_W'(1);
      end else if (width_ff > bec_pkg::CFG_W'(bec_pkg::MAX_WIDTH)) begin
         eff_w = bec_pkg::CFG_W'(bec_pkg::MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      m   = {W{1'b1}} >> (bec_pkg::CFG_W'(W) - eff_w);
      top = W'(1) << (eff_w - bec_pkg::CFG_W'(1));
   end

   // Erosion and the dilation checks for the row in the input register.
   always_comb begin
      cur       = in_row_ff & m;
      has1      = (rows_seen_ff != 2'd0);
      has2      = rows_seen_ff[1];
      above_cur = has1 ? (orig_prev_ff & m) : m;
      above     = has2 ? orig_prev2_ff : m;

      e1   = bec_pkg::hand3(above, m, top) & bec_pkg::hand3(orig_prev_ff, m, top)
             & bec_pkg::hand3(cur, m, top);
      dil1 = bec_pkg::hor3(ero_prev2_ff, m) | bec_pkg::hor3(ero_prev_ff, m)
             | bec_pkg::hor3(e1, m);
      ok1  = !has2 || (dil1 == (orig_prev2_ff & m));

      ero_prev2_in = has1 ? ero_prev_ff : ero_prev2_ff;
      ero_prev_in  = has1 ? e1 : ero_prev_ff;

      // Bottom row: the eroded rows above it are the updated ones.
      el   = bec_pkg::hand3(above_cur, m, top) & bec_pkg::hand3(cur, m, top);
      dil2 = bec_pkg::hor3(ero_prev2_in, m) | bec_pkg::hor3(ero_prev_in, m)
             | bec_pkg::hor3(el, m);
      ok2  = !has1 || (dil2 == (orig_prev_ff & m));
      dil3 = bec_pkg::hor3(ero_prev_in, m) | bec_pkg::hor3(el, m);
      ok3  = (dil3 == cur);
      verdict = still_ok_ff && ok1 && ok2 && ok3;

      word_a = '{eroded_row: e1, last_result: 1'b0, possible: 1'b0};
      word_b = '{eroded_row: el, last_result: 1'b1, possible: verdict};
      push_n = consume ? ({1'b0, has1} + {1'b0, in_last_ff}) : 2'd0;
   end

   // Image state update; the bottom row returns everything to its start.
   always_comb begin
      orig_prev_in  = orig_prev_ff;
      orig_prev2_in = orig_prev2_ff;
      rows_seen_in  = rows_seen_ff;
      still_ok_in   = still_ok_ff;
      if (consume && in_last_ff) begin
         orig_prev_in  = '0;
         orig_prev2_in = '0;
         rows_seen_in  = 2'd0;
         still_ok_in   = 1'b1;
      end else if (consume) begin
         orig_prev2_in = orig_prev_ff;
         orig_prev_in  = cur;
         rows_seen_in  = has2 ? rows_seen_ff : rows_seen_ff + 2'd1;
         still_ok_in   = still_ok_ff && ok1;
      end
   end

   // Queue pointers.
   always_comb begin
      rq_tail_in = rq_tail_ff + bec_pkg::RQ_PTR_W'(push_n);
      rq_head_in = pop ? rq_head_ff + bec_pkg::RQ_PTR_W'(1) : rq_head_ff;
      rq_cnt_in  = rq_cnt_ff + bec_pkg::RQ_CNT_W'(push_n) - bec_pkg::RQ_CNT_W'(pop);
   end

   assign rsp_ch.valid       = (rq_cnt_ff != '0);
   assign rsp_ch.eroded_row  = rq_mem_ff[rq_head_ff].eroded_row;
   assign rsp_ch.last_result = rq_mem_ff[rq_head_ff].last_result;
   assign rsp_ch.possible    = rq_mem_ff[rq_head_ff].possible;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bec_pkg::CFG_W'(bec_pkg::MAX_WIDTH);
         in_vld_ff    <= 1'b0;
         orig_prev_ff  <= '0;
         orig_prev2_ff <= '0;
         ero_prev_ff   <= '0;
         ero_prev2_ff  <= '0;
         rows_seen_ff <= 2'd0;
         still_ok_ff  <= 1'b1;
         rq_head_ff   <= '0;
         rq_tail_ff   <= '0;
         rq_cnt_ff    <= '0;
      end else begin
         width_ff      <= width_in;
         in_vld_ff     <= in_vld_in;
         orig_prev_ff  <= orig_prev_in;
         orig_prev2_ff <= orig_prev2_in;
         if (consume && in_last_ff) begin
            ero_prev_ff  <= '0;
            ero_prev2_ff <= '0;
         end else if (consume) begin
            ero_prev_ff  <= ero_prev_in;
            ero_prev2_ff <= ero_prev2_in;
         end
         rows_seen_ff <= rows_seen_in;
         still_ok_ff  <= still_ok_in;
         rq_head_ff   <= rq_head_in;
         rq_tail_ff   <= rq_tail_in;
         rq_cnt_ff    <= rq_cnt_in;
      end
   end

   // Payload registers: input row and queue words.
   always_ff @(posedge clock) begin
      in_row_ff  <= in_row_in;
      in_last_ff <= in_last_in;
      if (consume && has1) begin
         rq_mem_ff[rq_tail_ff] <= word_a;
      end
      if (consume && in_last_ff) begin
         rq_mem_ff[rq_tail_ff + bec_pkg::RQ_PTR_W'(has1)] <= word_b;
      end
   end

`ifndef SYNTHESIS
   a_rq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rq_cnt_ff <= bec_pkg::RQ_CNT_W'(bec_pkg::RQ_DEPTH))
      else $error("result queue overflow");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      consume && in_last_ff |=> rows_seen_ff == 2'd0 && still_ok_ff)
      else $error("image state not cleared after bottom row");

   a_verdict_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.last_result |-> !rsp_ch.possible)
      else $error("verdict on a non-final word");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push_n != 2'd0 |-> rq_cnt_ff <= bec_pkg::RQ_CNT_W'(bec_pkg::RQ_DEPTH - 2))
      else $error("row processed without room in result queue");
`endif

endmodule

`default_nettype wire
